FILE: rtl/i2cbb_pkg.sv
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants for the I2C bit-level master line sequencer.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  // Field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StepW    = 5;
  localparam int unsigned WaitW    = 17;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned HalfW    = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // Bits per byte and steps spent shifting one byte (three per bit)
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned ByteSteps = 3 * ByteBits;

  localparam logic [WaitW-1:0]  WaitMax       = {WaitW{1'b1}};
  localparam logic [LimitW-1:0] LimitReset    = 16'd255;
  localparam logic [HalfW-1:0]  HalfReset     = 8'd1;

  // Command codes
  typedef enum logic [OpW-1:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ACK_TIMEOUT = 1'b0,
    REG_HALF_PERIOD = 1'b1
  } cfg_reg_e;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // Remainder by three for a step number (values up to 31)
  function automatic logic [1:0] mod3(input logic [StepW-1:0] v);
    logic [StepW-1:0] r;
    r = v;
    if (r >= StepW'(15)) r = r - StepW'(15);
    if (r >= StepW'(9))  r = r - StepW'(9);
    if (r >= StepW'(6))  r = r - StepW'(6);
    if (r >= StepW'(3))  r = r - StepW'(3);
    return r[1:0];
  endfunction

endpackage

FILE: rtl/i2cbb_if.sv
// ----------------------------------------------------------------------------
// i2cbb_in_if / i2cbb_out_if
// Valid/ready channels carrying tick words into and line words out of the
// sequencer.
// ----------------------------------------------------------------------------
interface i2cbb_in_if;
  import i2cbb_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [ByteW-1:0] wr_byte;
  logic             send_ack;
  logic             sda_sample;

  modport source (output valid, output op, output wr_byte, output send_ack,
                  output sda_sample, input ready);
  modport sink   (input valid, input op, input wr_byte, input send_ack,
                  input sda_sample, output ready);
endinterface

interface i2cbb_out_if;
  import i2cbb_pkg::*;

  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_level;
  logic             sda_driven;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] rd_byte;
  logic             ack_missing;

  modport source (output valid, output scl_level, output sda_level,
                  output sda_driven, output busy_res, output done_res,
                  output rd_byte, output ack_missing, input ready);
  modport sink   (input valid, input scl_level, input sda_level,
                  input sda_driven, input busy_res, input done_res,
                  input rd_byte, input ack_missing, output ready);
endinterface

FILE: rtl/i2c_bitbang_master_core.sv
// ----------------------------------------------------------------------------
// i2c_bitbang_master_core
// I2C master line sequencer: one input word is one tick; each tick yields
// one word of SCL/SDA levels, drive enable and status.
//
//   channel | dir | handshake            | content
//   --------+-----+----------------------+--------------------------------
//   in_i    | in  | valid/ready          | op, wr_byte, send_ack, sda_sample
//   out_o   | out | valid/ready          | line levels, busy, done, rd_byte
//   cfg     | in  | cfg_we_i (no ready)  | cfg_idx_i, cfg_wdata_i
//
// One word per cycle unless stalled: the step logic handles a tick in the
// cycle it is accepted and its result sits in the output register the next
// cycle. The input is ready whenever the output register is empty or being
// taken, so a stalled sink holds at most one result and stops intake.
// Reset returns the sequencer to idle with SCL and SDA driven high.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  i2cbb_pkg::cfg_idx_t  cfg_idx_i,
  input  i2cbb_pkg::cfg_data_t cfg_wdata_i,
  i2cbb_in_if.sink             in_i,
  i2cbb_out_if.source          out_o
);
  import i2cbb_pkg::*;

  // Configuration registers
  logic [LimitW-1:0] limit_q;
  logic [HalfW-1:0]  half_q;

  // Sequencer state
  cmd_e              cmd_q,   cmd_d;
  logic [StepW-1:0]  step_q,  step_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic [WaitW-1:0]  wait_q,  wait_d;
  logic [HalfW-1:0]  pace_q,  pace_d;
  logic              scl_q,   scl_d;
  logic              sda_q,   sda_d;
  logic              drv_q,   drv_d;
  logic              ack_q,   ack_d;
  logic [ByteW-1:0]  rd_q,    rd_d;
  logic              to_q,    to_d;
  logic              done_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              o_scl_q, o_sda_q, o_drv_q, o_busy_q, o_done_q, o_miss_q;
  logic [ByteW-1:0]  o_rd_q;

  logic              in_fire;
  logic [HalfW-1:0]  hp;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign hp         = (half_q == '0) ? HalfW'(1) : half_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      half_q  <= HalfReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACK_TIMEOUT: limit_q <= cfg_wdata_i[LimitW-1:0];
        REG_HALF_PERIOD: half_q  <= cfg_wdata_i[HalfW-1:0];
        default: ;
      endcase
    end
  end

  // Step logic: take a command when idle, then pace and perform one action
  always_comb begin
    logic             fin;
    logic             hold;
    logic [1:0]       ph;
    logic [StepW-1:0] k;
    logic [WaitW-1:0] wait_nx;

    cmd_d   = cmd_q;
    step_d  = step_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    pace_d  = pace_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    ack_d   = ack_q;
    rd_d    = rd_q;
    to_d    = to_q;
    done_d  = 1'b0;
    fin     = 1'b0;
    hold    = 1'b0;
    ph      = '0;
    k       = '0;
    wait_nx = wait_q;

    if (in_fire) begin
      // new command, only from idle; codes above wait-ack mean nothing
      if (cmd_q == CMD_NONE && in_i.op inside {[CMD_START:CMD_WAIT]}) begin
        cmd_d  = cmd_e'(in_i.op);
        step_d = '0;
        pace_d = '0;
        case (cmd_e'(in_i.op))
          CMD_WRITE: shift_d = in_i.wr_byte;
          CMD_READ: begin
            shift_d = '0;
            ack_d   = in_i.send_ack;
          end
          CMD_WAIT: begin
            wait_d = '0;
            to_d   = 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd_d != CMD_NONE) begin
        if (pace_d != '0) begin
          pace_d = pace_d - HalfW'(1);
        end else begin
          case (cmd_d)
            CMD_START: begin
              case (step_d)
                StepW'(0): begin drv_d = 1'b1; sda_d = 1'b1; end
                StepW'(1): scl_d = 1'b1;
                StepW'(2): begin drv_d = 1'b1; sda_d = 1'b0; end
                StepW'(3): scl_d = 1'b0;
                default:   fin = 1'b1;
              endcase
            end
            CMD_STOP: begin
              case (step_d)
                StepW'(0): begin drv_d = 1'b1; sda_d = 1'b0; end
                StepW'(1): scl_d = 1'b1;
                StepW'(2): begin drv_d = 1'b1; sda_d = 1'b1; end
                default:   fin = 1'b1;
              endcase
            end
            CMD_WRITE: begin
              if (step_d == '0) begin
                drv_d = 1'b1;
                scl_d = 1'b0;
              end else if (step_d > StepW'(ByteSteps)) begin
                fin = 1'b1;
              end else begin
                ph = mod3(step_d - StepW'(1));
                case (ph)
                  2'd0: begin
                    drv_d   = 1'b1;
                    sda_d   = shift_d[ByteW-1];
                    shift_d = {shift_d[ByteW-2:0], 1'b0};
                  end
                  2'd1:    scl_d = 1'b1;
                  default: scl_d = 1'b0;
                endcase
              end
            end
            CMD_READ: begin
              if (step_d < StepW'(ByteSteps)) begin
                ph = mod3(step_d);
                case (ph)
                  2'd0: begin drv_d = 1'b0; scl_d = 1'b0; end
                  2'd1: scl_d = 1'b1;
                  default: shift_d = {shift_d[ByteW-2:0], in_i.sda_sample};
                endcase
              end else begin
                // acknowledge slot after the eighth bit; ACK pulls SDA low
                k = step_d - StepW'(ByteSteps);
                case (k)
                  StepW'(0): scl_d = 1'b0;
                  StepW'(1): begin drv_d = 1'b1; sda_d = !ack_d; end
                  StepW'(2): scl_d = 1'b1;
                  StepW'(3): scl_d = 1'b0;
                  default: begin
                    rd_d = shift_d;
                    fin  = 1'b1;
                  end
                endcase
              end
            end
            CMD_WAIT: begin
              case (step_d)
                StepW'(0): begin drv_d = 1'b1; sda_d = 1'b1; end
                StepW'(1): scl_d = 1'b1;
                StepW'(2): drv_d = 1'b0;
                StepW'(3): begin
                  // poll SDA each tick; a high sample counts towards timeout
                  if (in_i.sda_sample) begin
                    hold = 1'b1;
                    if (wait_d != WaitMax) wait_nx = wait_d + WaitW'(1);
                    else                   wait_nx = wait_d;
                    wait_d = wait_nx;
                    if (wait_nx > {1'b0, limit_q}) begin
                      to_d   = 1'b1;
                      cmd_d  = CMD_STOP;
                      step_d = '0;
                    end
                  end
                end
                StepW'(4): scl_d = 1'b0;
                default:   fin = 1'b1;
              endcase
            end
            default: fin = 1'b1;
          endcase

          if (fin) begin
            done_d = 1'b1;
            cmd_d  = CMD_NONE;
            step_d = '0;
          end else if (!hold) begin
            step_d = step_d + StepW'(1);
            pace_d = hp - HalfW'(1);
          end
        end
      end
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_NONE;
      step_q  <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      pace_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
      ack_q   <= 1'b0;
      rd_q    <= '0;
      to_q    <= 1'b0;
    end else begin
      cmd_q   <= cmd_d;
      step_q  <= step_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      pace_q  <= pace_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
      ack_q   <= ack_d;
      rd_q    <= rd_d;
      to_q    <= to_d;
    end
  end

  // Output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire)           out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      o_scl_q  <= scl_d;
      o_sda_q  <= sda_d;
      o_drv_q  <= drv_d;
      o_busy_q <= (cmd_d != CMD_NONE);
      o_done_q <= done_d;
      o_rd_q   <= rd_d;
      o_miss_q <= to_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.scl_level   = o_scl_q;
  assign out_o.sda_level   = o_sda_q;
  assign out_o.sda_driven  = o_drv_q;
  assign out_o.busy_res    = o_busy_q;
  assign out_o.done_res    = o_done_q;
  assign out_o.rd_byte     = o_rd_q;
  assign out_o.ack_missing = o_miss_q;

`ifndef SYNTH
  // A completing tick always leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_done_q |-> !o_busy_q)
    else $error("done reported while still busy");

  // Idle sequencer always sits at step zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CMD_NONE |-> step_q == '0)
    else $error("idle with non-zero step");

  // A held result that is not taken blocks intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("unaccepted result dropped");
`endif

endmodule
